// ===== design/tqt_quant_gradient_macros.svh =====
// Assertion macros shared by the quantisation gradient modules.
`ifndef TQT_QUANT_GRADIENT_MACROS_SVH
`define TQT_QUANT_GRADIENT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TQT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TQT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tqt_pkg.sv =====
// Shared types, codes and constants of the quantisation threshold gradient unit.
package tqt_pkg;

    localparam int DIV_STEPS = 48;
    localparam int MUL_STEPS = 5;
    localparam int CNT_W     = 6;
    localparam int ACC_W     = 110;

    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
    localparam logic [63:0] SUM_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_NEG_MAG = 64'h8000_0000_0000_0000;

    localparam logic [1:0] CFG_IDX_STEP_SCALE = 2'd0;
    localparam logic [1:0] CFG_IDX_LEVEL_MIN  = 2'd1;
    localparam logic [1:0] CFG_IDX_LEVEL_MAX  = 2'd2;

    localparam logic [31:0] RST_STEP_SCALE = 32'h0001_0000;
    localparam logic [15:0] RST_LEVEL_MIN  = 16'hFF80;
    localparam logic [15:0] RST_LEVEL_MAX  = 16'h007F;

    localparam logic [1:0] RANGE_IN    = 2'd0;
    localparam logic [1:0] RANGE_BELOW = 2'd1;
    localparam logic [1:0] RANGE_ABOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROUND,
        ST_MUL,
        ST_TERM,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_GS,
        MUL_LM,
        MUL_PL_LO,
        MUL_PL_HI,
        MUL_FP_LL,
        MUL_FP_LH,
        MUL_FP_HL,
        MUL_FP_HH
    } mul_op_t;

    typedef enum logic [2:0] {
        POST_NONE,
        POST_SAVE_P,
        POST_SAVE_LM,
        POST_SAVE_P2,
        POST_ACC_LOAD,
        POST_ACC_ADD32,
        POST_ACC_ADD64
    } post_op_t;

    typedef struct packed {
        logic [31:0] step_scale;
        logic [15:0] level_min;
        logic [15:0] level_max;
    } cfg_t;

    typedef struct packed {
        logic     load;
        logic     div_step;
        mul_op_t  mul_op;
        post_op_t post_op;
        logic     round;
        logic     term;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== design/tqt_cfg_regs.sv =====
// Configuration register file: step scale and level bounds.
module tqt_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output tqt_pkg::cfg_t      cfg
);

    logic [31:0] step_scale_reg;
    logic [15:0] level_min_reg;
    logic [15:0] level_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_scale_reg <= tqt_pkg::RST_STEP_SCALE;
            level_min_reg  <= tqt_pkg::RST_LEVEL_MIN;
            level_max_reg  <= tqt_pkg::RST_LEVEL_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tqt_pkg::CFG_IDX_STEP_SCALE: step_scale_reg <= cfg_data;
                tqt_pkg::CFG_IDX_LEVEL_MIN:  level_min_reg  <= cfg_data[15:0];
                tqt_pkg::CFG_IDX_LEVEL_MAX:  level_max_reg  <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.step_scale = step_scale_reg;
    assign cfg.level_min  = level_min_reg;
    assign cfg.level_max  = level_max_reg;

endmodule

// ===== design/tqt_ctrl.sv =====
// Controller state machine sequencing division, rounding, multiplies and commit.
`include "tqt_quant_gradient_macros.svh"

module tqt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tqt_pkg::status_t  status,
    output tqt_pkg::cmd_t     cmd
);

    tqt_pkg::state_t              state_reg;
    tqt_pkg::state_t              state_next;
    logic [tqt_pkg::CNT_W-1:0]    cnt_reg;
    logic [tqt_pkg::CNT_W-1:0]    cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tqt_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.mul_op  = tqt_pkg::MUL_NONE;
        cmd.post_op = tqt_pkg::POST_NONE;
        case (state_reg)
            tqt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = tqt_pkg::ST_DIV;
                end
            end
            tqt_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                // The scale and ln2 products run on the multiplier alongside the division.
                case (cnt_reg)
                    6'd0:
                    begin
                        cmd.mul_op = tqt_pkg::MUL_GS;
                    end
                    6'd1:
                    begin
                        cmd.post_op = tqt_pkg::POST_SAVE_P;
                        cmd.mul_op  = tqt_pkg::MUL_LM;
                    end
                    6'd2:
                    begin
                        cmd.post_op = tqt_pkg::POST_SAVE_LM;
                        cmd.mul_op  = tqt_pkg::MUL_PL_LO;
                    end
                    6'd3:
                    begin
                        cmd.post_op = tqt_pkg::POST_ACC_LOAD;
                        cmd.mul_op  = tqt_pkg::MUL_PL_HI;
                    end
                    6'd4:
                    begin
                        cmd.post_op = tqt_pkg::POST_ACC_ADD32;
                    end
                    6'd5:
                    begin
                        cmd.post_op = tqt_pkg::POST_SAVE_P2;
                    end
                    default:
                    begin
                    end
                endcase
                if (cnt_reg == tqt_pkg::CNT_W'(tqt_pkg::DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = tqt_pkg::ST_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tqt_pkg::ST_ROUND:
            begin
                cmd.round  = 1'b1;
                cnt_next   = '0;
                state_next = tqt_pkg::ST_MUL;
            end
            tqt_pkg::ST_MUL:
            begin
                case (cnt_reg)
                    6'd0:
                    begin
                        cmd.mul_op = tqt_pkg::MUL_FP_LL;
                    end
                    6'd1:
                    begin
                        cmd.post_op = tqt_pkg::POST_ACC_LOAD;
                        cmd.mul_op  = tqt_pkg::MUL_FP_LH;
                    end
                    6'd2:
                    begin
                        cmd.post_op = tqt_pkg::POST_ACC_ADD32;
                        cmd.mul_op  = tqt_pkg::MUL_FP_HL;
                    end
                    6'd3:
                    begin
                        cmd.post_op = tqt_pkg::POST_ACC_ADD32;
                        cmd.mul_op  = tqt_pkg::MUL_FP_HH;
                    end
                    default:
                    begin
                        cmd.post_op = tqt_pkg::POST_ACC_ADD64;
                    end
                endcase
                if (cnt_reg == tqt_pkg::CNT_W'(tqt_pkg::MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = tqt_pkg::ST_TERM;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tqt_pkg::ST_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = tqt_pkg::ST_DONE;
            end
            tqt_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = tqt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tqt_pkg::ST_IDLE;
            end
        endcase
    end

    `TQT_ASSERT_NXT(a_load_starts_div, clk, rst_n, cmd.load, (state_reg == tqt_pkg::ST_DIV) && (cnt_reg == '0), "A loaded word did not start the division.")

endmodule

// ===== design/tqt_datapath.sv =====
// Datapath: restoring divider, rounding, shared multiplier, accumulator and result register.
`include "tqt_quant_gradient_macros.svh"

module tqt_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tqt_pkg::cfg_t       cfg,
    input  tqt_pkg::cmd_t       cmd,
    output tqt_pkg::status_t    status,
    input  logic signed [31:0]  sample_value,
    input  logic signed [31:0]  upstream_grad,
    input  logic                final_element,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  masked_grad,
    output logic [1:0]          range_status,
    output logic signed [63:0]  threshold_grad_sum,
    output logic                last
);

    localparam int AW = tqt_pkg::ACC_W;

    logic                xneg_reg;
    logic                gneg_reg;
    logic                fin_reg;
    logic [31:0]         grad_in_reg;
    logic [31:0]         gm_reg;
    logic [31:0]         rem_reg;
    logic [47:0]         quo_reg;
    logic [63:0]         mul_reg;
    logic [62:0]         p_reg;
    logic [30:0]         lm_reg;
    logic [62:0]         p2_reg;
    logic [AW-1:0]       acc_reg;
    logic [46:0]         fm_reg;
    logic                fneg_reg;
    logic                lt_reg;
    logic                gt_reg;
    logic [63:0]         term_reg;
    logic [63:0]         gacc_reg;
    logic                out_valid_reg;
    logic [31:0]         masked_reg;
    logic [1:0]          status_reg;
    logic [63:0]         sum_reg;
    logic                last_reg;

    logic [31:0]         divisor;
    logic [32:0]         div_shift;
    logic                div_ge;
    logic [32:0]         div_diff;
    logic [31:0]         xm_in;
    logic [31:0]         gm_in;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [16:0]         lmin_abs;
    logic [16:0]         lmax_abs;
    logic [31:0]         q_int;
    logic [15:0]         q_frac;
    logic                sticky;
    logic                rnd_inc;
    logic [32:0]         rm;
    logic [33:0]         lvl;
    logic                lvl_lt;
    logic                lvl_gt;
    logic [16:0]         frac_mag;
    logic [46:0]         fm_next;
    logic                fneg_next;
    logic [AW-1:0]       acc_mul;
    logic [63:0]         mag;
    logic [63:0]         term_next;
    logic [63:0]         sum_raw;
    logic [63:0]         sum_sat;

    assign divisor   = (cfg.step_scale == 32'd0) ? 32'd1 : cfg.step_scale;
    assign div_shift = {rem_reg, quo_reg[47]};
    assign div_ge    = div_shift >= {1'b0, divisor};
    assign div_diff  = div_shift - {1'b0, divisor};

    assign xm_in = sample_value[31] ? (32'd0 - $unsigned(sample_value)) : $unsigned(sample_value);
    assign gm_in = upstream_grad[31] ? (32'd0 - $unsigned(upstream_grad))
                                     : $unsigned(upstream_grad);

    assign lmin_abs = cfg.level_min[15] ? (17'd0 - {cfg.level_min[15], cfg.level_min})
                                        : {1'b0, cfg.level_min};
    assign lmax_abs = cfg.level_max[15] ? (17'd0 - {cfg.level_max[15], cfg.level_max})
                                        : {1'b0, cfg.level_max};

    always_comb
    begin
        case (cmd.mul_op)
            tqt_pkg::MUL_GS:
            begin
                mul_a = gm_reg;
                mul_b = cfg.step_scale;
            end
            tqt_pkg::MUL_LM:
            begin
                mul_a = {15'd0, lmin_abs};
                mul_b = {15'd0, lmax_abs};
            end
            tqt_pkg::MUL_PL_LO:
            begin
                mul_a = p_reg[31:0];
                mul_b = tqt_pkg::LN2_Q32;
            end
            tqt_pkg::MUL_PL_HI:
            begin
                mul_a = {1'b0, p_reg[62:32]};
                mul_b = tqt_pkg::LN2_Q32;
            end
            tqt_pkg::MUL_FP_LL:
            begin
                mul_a = p2_reg[31:0];
                mul_b = fm_reg[31:0];
            end
            tqt_pkg::MUL_FP_LH:
            begin
                mul_a = p2_reg[31:0];
                mul_b = {17'd0, fm_reg[46:32]};
            end
            tqt_pkg::MUL_FP_HL:
            begin
                mul_a = {1'b0, p2_reg[62:32]};
                mul_b = fm_reg[31:0];
            end
            tqt_pkg::MUL_FP_HH:
            begin
                mul_a = {1'b0, p2_reg[62:32]};
                mul_b = {17'd0, fm_reg[46:32]};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // Rounding: ties to even for a non-negative quotient, towards plus infinity otherwise.
    assign q_int    = quo_reg[47:16];
    assign q_frac   = quo_reg[15:0];
    assign sticky   = rem_reg != 32'd0;
    assign rnd_inc  = (q_frac[15] && ((q_frac[14:0] != 15'd0) || sticky))
                   || ((q_frac == 16'h8000) && !sticky && !xneg_reg && q_int[0]);
    assign rm       = {1'b0, q_int} + {32'd0, rnd_inc};
    assign lvl      = xneg_reg ? (34'd0 - {1'b0, rm}) : {1'b0, rm};
    assign lvl_lt   = $signed(lvl) < $signed({{18{cfg.level_min[15]}}, cfg.level_min});
    assign lvl_gt   = $signed(lvl) > $signed({{18{cfg.level_max[15]}}, cfg.level_max});
    assign frac_mag = rnd_inc ? (17'h10000 - {1'b0, q_frac}) : {1'b0, q_frac};

    always_comb
    begin
        if (lvl_lt && lvl_gt)
        begin
            fm_next   = {lm_reg, 16'd0};
            fneg_next = cfg.level_min[15] ^ cfg.level_max[15];
        end
        else if (lvl_lt)
        begin
            fm_next   = {14'd0, lmin_abs, 16'd0};
            fneg_next = cfg.level_min[15];
        end
        else if (lvl_gt)
        begin
            fm_next   = {14'd0, lmax_abs, 16'd0};
            fneg_next = cfg.level_max[15];
        end
        else
        begin
            fm_next   = {30'd0, frac_mag};
            fneg_next = !rnd_inc ^ xneg_reg;
        end
    end

    assign acc_mul = {{(AW-64){1'b0}}, mul_reg};

    assign mag       = (acc_reg[AW-1:80] != '0) ? {64{1'b1}} : acc_reg[79:16];
    assign term_next = (gneg_reg ^ fneg_reg)
        ? (64'd0 - ((mag > tqt_pkg::SUM_NEG_MAG) ? tqt_pkg::SUM_NEG_MAG : mag))
        : ((mag > tqt_pkg::SUM_POS_MAX) ? tqt_pkg::SUM_POS_MAX : mag);

    assign sum_raw = gacc_reg + term_reg;
    assign sum_sat = ((gacc_reg[63] == term_reg[63]) && (sum_raw[63] != term_reg[63]))
                   ? (term_reg[63] ? tqt_pkg::SUM_NEG_MAG : tqt_pkg::SUM_POS_MAX)
                   : sum_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gacc_reg      <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                gacc_reg <= fin_reg ? 64'd0 : sum_sat;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xneg_reg    <= sample_value[31];
            gneg_reg    <= upstream_grad[31];
            fin_reg     <= final_element;
            grad_in_reg <= upstream_grad;
            gm_reg      <= gm_in;
            quo_reg     <= {xm_in, 16'd0};
            rem_reg     <= 32'd0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[46:0], div_ge};
            rem_reg <= div_ge ? div_diff[31:0] : div_shift[31:0];
        end

        if (cmd.mul_op != tqt_pkg::MUL_NONE)
        begin
            mul_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        end

        case (cmd.post_op)
            tqt_pkg::POST_SAVE_P:    p_reg   <= mul_reg[62:0];
            tqt_pkg::POST_SAVE_LM:   lm_reg  <= mul_reg[30:0];
            tqt_pkg::POST_SAVE_P2:   p2_reg  <= acc_reg[94:32];
            tqt_pkg::POST_ACC_LOAD:  acc_reg <= acc_mul;
            tqt_pkg::POST_ACC_ADD32: acc_reg <= acc_reg + (acc_mul << 32);
            tqt_pkg::POST_ACC_ADD64: acc_reg <= acc_reg + (acc_mul << 64);
            default:
            begin
            end
        endcase

        if (cmd.round)
        begin
            fm_reg   <= fm_next;
            fneg_reg <= fneg_next;
            lt_reg   <= lvl_lt;
            gt_reg   <= lvl_gt;
        end

        if (cmd.term)
        begin
            term_reg <= term_next;
        end

        if (cmd.commit)
        begin
            masked_reg <= (lt_reg || gt_reg) ? 32'd0 : grad_in_reg;
            status_reg <= lt_reg ? tqt_pkg::RANGE_BELOW
                        : (gt_reg ? tqt_pkg::RANGE_ABOVE : tqt_pkg::RANGE_IN);
            sum_reg    <= fin_reg ? sum_sat : 64'd0;
            last_reg   <= fin_reg;
        end
    end

    assign status.out_free    = !out_valid_reg || out_ready;
    assign out_valid          = out_valid_reg;
    assign masked_grad        = $signed(masked_reg);
    assign range_status       = status_reg;
    assign threshold_grad_sum = $signed(sum_reg);
    assign last               = last_reg;

    `TQT_ASSERT_NXT(a_commit_shows_word, clk, rst_n, cmd.commit, out_valid_reg, "A committed word is not presented.")
    `TQT_ASSERT_NXT(a_last_clears_sum, clk, rst_n, cmd.commit && fin_reg, gacc_reg == 64'd0, "The accumulator was not cleared after the last element.")
    `TQT_ASSERT_IMP(a_sum_only_on_last, clk, rst_n, out_valid_reg && !last_reg, sum_reg == 64'd0, "A sum is shown on a word that is not the last.")
    `TQT_ASSERT_IMP(a_mask_out_of_range, clk, rst_n, out_valid_reg && (status_reg != tqt_pkg::RANGE_IN), masked_reg == 32'd0, "The gradient passed for a level out of range.")

endmodule

// ===== design/tqt_quant_gradient.sv =====
// Top level of the quantisation threshold gradient unit.
// Each input word is divided by the step scale in a restoring divider that yields one of 48
// quotient bits per cycle; the rounded level is checked against the bounds, and the threshold
// gradient term is formed on one shared 32 by 32 multiplier (the scale and ln2 products run
// during the division, the four factor products after it) before a saturating add into the
// Q32.32 sum. A word is accepted only while the unit is idle, so the next word is taken only
// after the previous result is committed. The finished result waits in an output register,
// and the next word is taken meanwhile.
module tqt_quant_gradient (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sample_value,
    input  logic signed [31:0] upstream_grad,
    input  logic               final_element,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] masked_grad,
    output logic [1:0]         range_status,
    output logic signed [63:0] threshold_grad_sum,
    output logic               last
);

    tqt_pkg::cfg_t    cfg;
    tqt_pkg::cmd_t    cmd;
    tqt_pkg::status_t status;

    tqt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tqt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tqt_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .cmd                (cmd),
        .status             (status),
        .sample_value       (sample_value),
        .upstream_grad      (upstream_grad),
        .final_element      (final_element),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .masked_grad        (masked_grad),
        .range_status       (range_status),
        .threshold_grad_sum (threshold_grad_sum),
        .last               (last)
    );

endmodule
